// ===== sv/tga_pkg.sv =====
`default_nettype none

package tga_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_RLE    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [7:0] BPP_RESET = 8'd24;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_PAST_END    = 2'd2;
  localparam logic [1:0] ST_CLAMPED     = 2'd3;

  localparam logic [7:0] RLE_RUN_BIT   = 8'd128;
  localparam logic [7:0] RLE_RUN_BIAS  = 8'd127;
  localparam logic [7:0] CHAN_5B_MASK  = 8'h1f;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  bits_per_pixel;
    logic        run_length_mode;
    logic [15:0] pixels_per_row;
    logic [15:0] row_count;
    logic [31:0] pixel_total;
  } cfg_t;

  // Bytes per pixel for a depth; zero marks an unsupported depth
  function automatic logic [2:0] bytes_per_pixel(input logic [7:0] bpp);
    logic [2:0] n;
    case (bpp)
      8'd16:   n = 3'd2;
      8'd24:   n = 3'd3;
      8'd32:   n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tga_pixel_stream_decoder.sv =====
// Results are registered: out_r takes a new result when free, else skid_r holds it.
// Throughput: one byte per cycle; a two-entry output buffer lets a byte in
// while one result waits, so in_ready drops only when two results are held.
// Header bytes and partial-pixel bytes give no result unless the depth is unsupported or the image is past its end.
// Reset (rst_n low, synchronous): registers return to 24-bit uncompressed,
// zero size; packet state, pixel count and the output buffer are cleared.
`default_nettype none

module tga_pixel_stream_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire tga_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tga_pkg::out_item_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tga_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tga_pkg::DATA_W-1:0] pwdata,
  output logic      [tga_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import tga_pkg::*;

  cfg_t      cfg;
  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;
  logic      space;

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  tga_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  tga_decode_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  tga_out_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire && res_valid),
    .push_item(res_item),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_data)
  );

  // A stall on the input means both buffer entries are full
  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_clamp_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_CLAMPED |-> out_data.last_pixel)
    else $error("clamped run not flagged as last pixel");

  a_error_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_UNSUPPORTED || out_data.status == ST_PAST_END)
    |-> out_data.repeat_count == 8'd0 && !out_data.last_pixel)
    else $error("error result carries a pixel");

  a_ok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.repeat_count != 8'd0)
    else $error("pixel result with zero repeat count");

endmodule

`default_nettype wire

// ===== sv/tga_cfg_regs.sv =====
`default_nettype none

module tga_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tga_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tga_pkg::DATA_W-1:0] pwdata,
  output logic      [tga_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tga_pkg::cfg_t                   cfg
);
  import tga_pkg::*;

  logic [7:0]  bpp_r;
  logic        rle_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Keep width*height registered so the start byte needs no multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RESET;
      rle_r    <= 1'b0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      total_r  <= 32'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BPP:    bpp_r <= pwdata[7:0];
        REG_RLE:    rle_r <= pwdata[0];
        REG_WIDTH: begin
          width_r <= pwdata[15:0];
          total_r <= {16'd0, pwdata[15:0]} * {16'd0, height_r};
        end
        REG_HEIGHT: begin
          height_r <= pwdata[15:0];
          total_r  <= {16'd0, width_r} * {16'd0, pwdata[15:0]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BPP:    prdata = {24'd0, bpp_r};
      REG_RLE:    prdata = {31'd0, rle_r};
      REG_WIDTH:  prdata = {16'd0, width_r};
      REG_HEIGHT: prdata = {16'd0, height_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{bits_per_pixel:  bpp_r,
                 run_length_mode: rle_r,
                 pixels_per_row:  width_r,
                 row_count:       height_r,
                 pixel_total:     total_r};

endmodule

`default_nettype wire

// ===== sv/tga_decode_core.sv =====
`default_nettype none

module tga_decode_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tga_pkg::cfg_t     cfg,
  input  wire logic              in_fire,
  input  wire tga_pkg::in_item_t in_item,
  output logic                   res_valid,
  output tga_pkg::out_item_t     res_item
);
  import tga_pkg::*;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [7:0]  ppl_r, ppl_nxt, ppl_cur;
  logic [1:0]  bip_r, bip_nxt, bip_cur;
  logic [23:0] gath_r, gath_nxt, gath_cur;
  logic [31:0] ipl_r, ipl_nxt, ipl_cur;

  logic [2:0]  nbytes;
  logic        rle;
  logic        unsupported;
  logic [7:0]  data;
  logic [7:0]  p0, p1, p2, p3;
  logic [15:0] word16;
  logic [7:0]  cnt, cnt_run;
  logic [31:0] ipl_after;

  always_comb begin
    data = in_item.data_byte;
    rle  = cfg.run_length_mode;
    nbytes = bytes_per_pixel(cfg.bits_per_pixel);
    unsupported = (nbytes == 3'd0) || (rle && nbytes == 3'd2);

    // Start of image reloads the count and clears packet state first
    if (in_item.start_of_image) begin
      ipl_cur   = cfg.pixel_total;
      phase_cur = PH_HEADER;
      ppl_cur   = 8'd0;
      bip_cur   = 2'd0;
      gath_cur  = 24'd0;
    end else begin
      ipl_cur   = ipl_r;
      phase_cur = phase_r;
      ppl_cur   = ppl_r;
      bip_cur   = bip_r;
      gath_cur  = gath_r;
    end

    ipl_nxt   = ipl_cur;
    phase_nxt = phase_cur;
    ppl_nxt   = ppl_cur;
    bip_nxt   = bip_cur;
    gath_nxt  = gath_cur;
    res_valid = 1'b0;
    res_item  = '0;

    p0 = gath_cur[7:0];
    p1 = gath_cur[15:8];
    p2 = gath_cur[23:16];
    p3 = 8'd0;
    case (bip_cur)
      2'd0:    p0 = data;
      2'd1:    p1 = data;
      2'd2:    p2 = data;
      default: p3 = data;
    endcase
    word16 = {p1, p0};

    cnt_run   = (ppl_cur != 8'd0) ? ppl_cur : 8'd1;
    cnt       = 8'd1;
    ipl_after = ipl_cur;

    if (unsupported) begin
      res_valid       = 1'b1;
      res_item.status = ST_UNSUPPORTED;
    end else if (ipl_cur == 32'd0) begin
      res_valid       = 1'b1;
      res_item.status = ST_PAST_END;
    end else if (rle && phase_cur == PH_HEADER) begin
      if (data < RLE_RUN_BIT) begin
        phase_nxt = PH_RAW;
        ppl_nxt   = data + 8'd1;
      end else begin
        phase_nxt = PH_RUN;
        ppl_nxt   = data - RLE_RUN_BIAS;
      end
      bip_nxt  = 2'd0;
      gath_nxt = 24'd0;
    end else if ({1'b0, bip_cur} + 3'd1 < nbytes) begin
      // Gather a byte of a partial pixel
      case (bip_cur)
        2'd0:    gath_nxt[7:0]   = gath_cur[7:0] | data;
        2'd1:    gath_nxt[15:8]  = gath_cur[15:8] | data;
        default: gath_nxt[23:16] = gath_cur[23:16] | data;
      endcase
      bip_nxt = bip_cur + 2'd1;
    end else begin
      bip_nxt   = 2'd0;
      gath_nxt  = 24'd0;
      res_valid = 1'b1;
      if (nbytes == 3'd2) begin
        res_item.blue  = {word16[4:0], 3'b000};
        res_item.green = {word16[9:5], 3'b000};
        res_item.red   = {word16[14:10], 3'b000};
        res_item.alpha = 8'd0;
      end else begin
        res_item.blue  = p0;
        res_item.green = p1;
        res_item.red   = p2;
        res_item.alpha = (nbytes == 3'd4) ? p3 : 8'd0;
      end

      if (rle && phase_cur == PH_RUN) begin
        cnt       = cnt_run;
        phase_nxt = PH_HEADER;
        ppl_nxt   = 8'd0;
      end else if (rle && phase_cur == PH_RAW) begin
        ppl_nxt = ppl_cur - 8'd1;
        if (ppl_nxt == 8'd0) begin
          phase_nxt = PH_HEADER;
        end
      end

      res_item.status = ST_OK;
      // Clamp a run that reaches past the image end
      if ({24'd0, cnt} > ipl_cur) begin
        cnt             = ipl_cur[7:0];
        res_item.status = ST_CLAMPED;
      end
      ipl_after = ipl_cur - {24'd0, cnt};
      ipl_nxt   = ipl_after;
      res_item.repeat_count = cnt;
      res_item.last_pixel   = (ipl_after == 32'd0);
      if (ipl_after == 32'd0) begin
        phase_nxt = PH_HEADER;
        ppl_nxt   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      ppl_r   <= 8'd0;
      bip_r   <= 2'd0;
      gath_r  <= 24'd0;
      ipl_r   <= 32'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      ppl_r   <= ppl_nxt;
      bip_r   <= bip_nxt;
      gath_r  <= gath_nxt;
      ipl_r   <= ipl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tga_out_skid.sv =====
`default_nettype none

module tga_out_skid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tga_pkg::out_item_t push_item,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tga_pkg::out_item_t      out_item
);
  import tga_pkg::*;

  logic      out_v_r;
  logic      skid_v_r;
  out_item_t out_r;
  out_item_t skid_r;
  logic      pop;

  assign pop       = out_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // Input is stalled; drain the skid entry first
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_r <= push_item;
      end else begin
        out_r <= push_item;
      end
    end
  end

endmodule

`default_nettype wire
